// ----- rtl/pad_pkg.sv -----
`default_nettype none
package pad_pkg;

  localparam int unsigned BASELINE_SAMPLES = 15;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = SAMPLE_W + 1;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned CNT_W    = $clog2(BASELINE_SAMPLES + 1);
  localparam int unsigned SUM_W    = LEVEL_W + CNT_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;

  localparam logic [CNT_W-1:0] BASE_TARGET = CNT_W'(BASELINE_SAMPLES);

  localparam logic [THR_W-1:0] SEVERE_THRESHOLD_RST   = THR_W'(50);
  localparam logic [THR_W-1:0] MIN_BASELINE_LEVEL_RST = THR_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEVERE_THRESHOLD   = 1'b0,
    CFG_MIN_BASELINE_LEVEL = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SPEED_LEAVE   = 2'd0,
    SPEED_DECEL   = 2'd1,
    SPEED_RESTORE = 2'd2
  } speed_action_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] range_sample;
    logic                automatic_mode;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] filtered_level_x2;
    logic               baseline_ready;
    logic               inspection_active;
    logic               inspection_started;
    speed_action_t      speed_action;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/pad_core.sv -----
`default_nettype none
module pad_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire pad_pkg::item_t               item,
  input  wire logic [pad_pkg::THR_W-1:0]    severe_threshold,
  input  wire logic [pad_pkg::THR_W-1:0]    min_baseline_level,
  output pad_pkg::result_t                  result
);

  logic [pad_pkg::SAMPLE_W-1:0] previous_sample;
  logic                         window_full;
  logic                         have_first_sample;
  logic [pad_pkg::SUM_W-1:0]    baseline_sum_x2;
  logic [pad_pkg::CNT_W-1:0]    baseline_count;
  logic                         inspecting;

  logic                         window_full_next;
  logic [pad_pkg::SUM_W-1:0]    baseline_sum_x2_next;
  logic [pad_pkg::CNT_W-1:0]    baseline_count_next;
  logic                         inspecting_next;

  logic [pad_pkg::LEVEL_W-1:0]  mean_x2;
  logic [pad_pkg::LEVEL_W-1:0]  min_x2;
  logic                         filling;
  logic [pad_pkg::SUM_W-1:0]    scaled;
  logic [pad_pkg::SUM_W-1:0]    dev;
  logic [pad_pkg::SUM_W-1:0]    limit;
  logic                         severe;
  logic                         started;
  pad_pkg::speed_action_t       action;

  always_comb begin
    if (have_first_sample) begin
      mean_x2 = pad_pkg::LEVEL_W'(previous_sample) + pad_pkg::LEVEL_W'(item.range_sample);
    end else begin
      mean_x2 = {item.range_sample, 1'b0};
    end
    window_full_next = window_full | have_first_sample;
    min_x2 = {min_baseline_level, 1'b0};
    filling = baseline_count < pad_pkg::BASE_TARGET;

    scaled = pad_pkg::SUM_W'(pad_pkg::BASE_TARGET) * pad_pkg::SUM_W'(mean_x2);
    dev = (scaled >= baseline_sum_x2) ? scaled - baseline_sum_x2 : baseline_sum_x2 - scaled;
    limit = pad_pkg::SUM_W'(pad_pkg::BASE_TARGET) * pad_pkg::SUM_W'({severe_threshold, 1'b0});
    severe = dev > limit;

    baseline_sum_x2_next = baseline_sum_x2;
    baseline_count_next  = baseline_count;
    inspecting_next      = inspecting;
    started              = 1'b0;
    action               = pad_pkg::SPEED_LEAVE;

    if (filling) begin
      if (window_full_next && (mean_x2 > min_x2)) begin
        baseline_sum_x2_next = baseline_sum_x2 + pad_pkg::SUM_W'(mean_x2);
        baseline_count_next  = baseline_count + pad_pkg::CNT_W'(1);
      end
    end else if (severe) begin
      if (!inspecting) begin
        inspecting_next = 1'b1;
        started         = 1'b1;
        if (item.automatic_mode) begin
          action = pad_pkg::SPEED_DECEL;
        end
      end
    end else if (inspecting) begin
      inspecting_next = 1'b0;
      action          = pad_pkg::SPEED_RESTORE;
    end

    result.filtered_level_x2  = mean_x2;
    result.baseline_ready     = baseline_count_next >= pad_pkg::BASE_TARGET;
    result.inspection_active  = inspecting_next;
    result.inspection_started = started;
    result.speed_action       = action;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_full       <= 1'b0;
      have_first_sample <= 1'b0;
      baseline_sum_x2   <= '0;
      baseline_count    <= '0;
      inspecting        <= 1'b0;
      previous_sample   <= '0;
    end else if (advance) begin
      window_full       <= window_full_next;
      have_first_sample <= 1'b1;
      baseline_sum_x2   <= baseline_sum_x2_next;
      baseline_count    <= baseline_count_next;
      inspecting        <= inspecting_next;
      previous_sample   <= item.range_sample;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/profile_anomaly_detector.sv -----
// An accepted sample transaction passes through the input register and then the result register.
// Throughput: one sample per cycle while result_ready does not stall; the mean, baseline
// update and deviation compare all sit in one combinational stage between the two registers.
// Reset (rst, synchronous): clears history, baseline and inspection state,
// empties both registers and loads threshold 50 and minimum level 100.
`default_nettype none
module profile_anomaly_detector (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  output logic                                 sample_ready,
  input  wire logic [pad_pkg::SAMPLE_W-1:0]    range_sample,
  input  wire logic                            automatic_mode,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output logic [pad_pkg::LEVEL_W-1:0]          filtered_level_x2,
  output logic                                 baseline_ready,
  output logic                                 inspection_active,
  output logic                                 inspection_started,
  output logic [1:0]                           speed_action,
  input  wire logic                            cfg_write,
  input  wire logic [pad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pad_pkg::CFG_W-1:0]       cfg_data
);

  logic [pad_pkg::THR_W-1:0] severe_threshold;
  logic [pad_pkg::THR_W-1:0] min_baseline_level;

  logic             in_full;
  pad_pkg::item_t   in_item;
  logic             advance;
  pad_pkg::result_t core_result;
  pad_pkg::result_t out_result;

  assign advance      = in_full && (!result_valid || result_ready);
  assign sample_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      severe_threshold   <= pad_pkg::SEVERE_THRESHOLD_RST;
      min_baseline_level <= pad_pkg::MIN_BASELINE_LEVEL_RST;
    end else if (cfg_write) begin
      unique case (pad_pkg::cfg_reg_t'(cfg_index))
        pad_pkg::CFG_SEVERE_THRESHOLD:   severe_threshold   <= cfg_data;
        pad_pkg::CFG_MIN_BASELINE_LEVEL: min_baseline_level <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (sample_ready) begin
      in_full <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      in_item.range_sample   <= range_sample;
      in_item.automatic_mode <= automatic_mode;
    end
  end

  pad_core u_core (
    .clk                (clk),
    .rst                (rst),
    .advance            (advance),
    .item               (in_item),
    .severe_threshold   (severe_threshold),
    .min_baseline_level (min_baseline_level),
    .result             (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign filtered_level_x2  = out_result.filtered_level_x2;
  assign baseline_ready     = out_result.baseline_ready;
  assign inspection_active  = out_result.inspection_active;
  assign inspection_started = out_result.inspection_started;
  assign speed_action       = out_result.speed_action;

  a_start_implies_active: assert property (@(posedge clk) disable iff (rst)
    result_valid && inspection_started |-> inspection_active && baseline_ready)
    else $error("inspection started without active inspection or baseline");

  a_decel_only_on_start: assert property (@(posedge clk) disable iff (rst)
    result_valid && (speed_action == pad_pkg::SPEED_DECEL) |-> inspection_started)
    else $error("deceleration requested without a new inspection");

  a_restore_clears: assert property (@(posedge clk) disable iff (rst)
    result_valid && (speed_action == pad_pkg::SPEED_RESTORE)
      |-> !inspection_active && !inspection_started)
    else $error("restore issued while inspection still active");

  a_no_action_filling: assert property (@(posedge clk) disable iff (rst)
    result_valid && !baseline_ready |-> !inspection_active && (speed_action == pad_pkg::SPEED_LEAVE))
    else $error("inspection activity before baseline complete");

endmodule
`default_nettype wire

// ----- test/profile_anomaly_detector_tb.sv -----
`default_nettype none
module profile_anomaly_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned THR_SET [NUM_PHASES] = '{0, 65535, 50, 20, 300, 5, 1000, 120};
  localparam int unsigned LVL_SET [NUM_PHASES] = '{0, 65535, 100, 2000, 40000, 7, 65535, 0};

  class anomaly_scoreboard;
    logic [pad_pkg::THR_W-1:0]    severe_thr = pad_pkg::SEVERE_THRESHOLD_RST;
    logic [pad_pkg::THR_W-1:0]    min_level  = pad_pkg::MIN_BASELINE_LEVEL_RST;
    logic [pad_pkg::SAMPLE_W-1:0] prev_sample = '0;
    bit                           window_full = 1'b0;
    bit                           have_first = 1'b0;
    int unsigned                  base_sum_x2 = 0;
    int unsigned                  base_count = 0;
    bit                           inspecting = 1'b0;
    pad_pkg::result_t             pending_levels[$];
    int unsigned                  errors = 0;
    int unsigned                  n_samples = 0;
    int unsigned                  n_results = 0;
    int unsigned                  n_started = 0;
    int unsigned                  n_restored = 0;

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %0s", $time, what);
    endtask

    function void set_reg(pad_pkg::cfg_reg_t idx, logic [pad_pkg::CFG_W-1:0] val);
      if (idx == pad_pkg::CFG_SEVERE_THRESHOLD) severe_thr = val;
      else min_level = val;
    endfunction

    function int unsigned pending();
      return pending_levels.size();
    endfunction

    // Baseline mean in sample units, used to center the random stimulus.
    function int baseline_center();
      return (base_count == 0) ? 1000 : int'(base_sum_x2 / (2 * base_count));
    endfunction

    function void take_sample(logic [pad_pkg::SAMPLE_W-1:0] s, logic auto_mode);
      logic [pad_pkg::LEVEL_W-1:0] mean_x2;
      int unsigned                 scaled;
      int unsigned                 dev;
      int unsigned                 lim;
      pad_pkg::result_t            r;
      r = '0;
      r.speed_action = pad_pkg::SPEED_LEAVE;
      if (!have_first) begin
        mean_x2 = {s, 1'b0};
        have_first = 1'b1;
      end else begin
        mean_x2 = pad_pkg::LEVEL_W'(prev_sample) + pad_pkg::LEVEL_W'(s);
        window_full = 1'b1;
      end
      prev_sample = s;
      if (base_count < pad_pkg::BASELINE_SAMPLES) begin
        if (window_full && mean_x2 > {min_level, 1'b0}) begin
          base_sum_x2 += mean_x2;
          base_count++;
        end
      end else begin
        scaled = pad_pkg::BASELINE_SAMPLES * int'(mean_x2);
        dev = (scaled >= base_sum_x2) ? scaled - base_sum_x2 : base_sum_x2 - scaled;
        lim = 2 * pad_pkg::BASELINE_SAMPLES * int'(severe_thr);
        if (dev > lim) begin
          if (!inspecting) begin
            inspecting = 1'b1;
            r.inspection_started = 1'b1;
            n_started++;
            if (auto_mode) r.speed_action = pad_pkg::SPEED_DECEL;
          end
        end else if (inspecting) begin
          inspecting = 1'b0;
          r.speed_action = pad_pkg::SPEED_RESTORE;
          n_restored++;
        end
      end
      r.filtered_level_x2 = mean_x2;
      r.baseline_ready = (base_count >= pad_pkg::BASELINE_SAMPLES);
      r.inspection_active = inspecting;
      pending_levels = {pending_levels, r};
      n_samples++;
    endfunction

    task check_result(pad_pkg::result_t got);
      pad_pkg::result_t exp;
      n_results++;
      if (pending_levels.size() == 0) begin
        report("result transaction with no sample pending");
      end else begin
        exp = pending_levels.pop_front();
        if (got.filtered_level_x2 !== exp.filtered_level_x2)
          report($sformatf("filtered_level_x2 got %0d exp %0d",
                           got.filtered_level_x2, exp.filtered_level_x2));
        if (got.baseline_ready !== exp.baseline_ready)
          report($sformatf("baseline_ready got %b exp %b",
                           got.baseline_ready, exp.baseline_ready));
        if (got.inspection_active !== exp.inspection_active)
          report($sformatf("inspection_active got %b exp %b",
                           got.inspection_active, exp.inspection_active));
        if (got.inspection_started !== exp.inspection_started)
          report($sformatf("inspection_started got %b exp %b",
                           got.inspection_started, exp.inspection_started));
        if (got.speed_action !== exp.speed_action)
          report($sformatf("speed_action got %0d exp %0d",
                           got.speed_action, exp.speed_action));
      end
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            sample_valid = 1'b0;
  logic                            sample_ready;
  logic [pad_pkg::SAMPLE_W-1:0]    range_sample = '0;
  logic                            automatic_mode = 1'b0;
  logic                            result_valid;
  logic                            result_ready = 1'b0;
  logic [pad_pkg::LEVEL_W-1:0]     filtered_level_x2;
  logic                            baseline_ready;
  logic                            inspection_active;
  logic                            inspection_started;
  logic [1:0]                      speed_action;
  logic                            cfg_write = 1'b0;
  logic [pad_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [pad_pkg::CFG_W-1:0]       cfg_data = '0;

  anomaly_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  pad_pkg::result_t got_r;

  profile_anomaly_detector uut (
    .clk                (clk),
    .rst                (rst),
    .sample_valid       (sample_valid),
    .sample_ready       (sample_ready),
    .range_sample       (range_sample),
    .automatic_mode     (automatic_mode),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .filtered_level_x2  (filtered_level_x2),
    .baseline_ready     (baseline_ready),
    .inspection_active  (inspection_active),
    .inspection_started (inspection_started),
    .speed_action       (speed_action),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      got_r.filtered_level_x2  = filtered_level_x2;
      got_r.baseline_ready     = baseline_ready;
      got_r.inspection_active  = inspection_active;
      got_r.inspection_started = inspection_started;
      got_r.speed_action       = pad_pkg::speed_action_t'(speed_action);
      sb.check_result(got_r);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task send_sample(input int unsigned s, input bit auto_mode);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid   <= 1'b1;
    range_sample   <= pad_pkg::SAMPLE_W'(s);
    automatic_mode <= auto_mode;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    sb.take_sample(pad_pkg::SAMPLE_W'(s), auto_mode);
  endtask

  task wait_drained();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_regs(input int unsigned thr, input int unsigned lvl);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= pad_pkg::CFG_SEVERE_THRESHOLD;
    cfg_data  <= pad_pkg::CFG_W'(thr);
    sb.set_reg(pad_pkg::CFG_SEVERE_THRESHOLD, pad_pkg::CFG_W'(thr));
    @(negedge clk);
    cfg_index <= pad_pkg::CFG_MIN_BASELINE_LEVEL;
    cfg_data  <= pad_pkg::CFG_W'(lvl);
    sb.set_reg(pad_pkg::CFG_MIN_BASELINE_LEVEL, pad_pkg::CFG_W'(lvl));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned thr;
    int          spread;
    int          v;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_regs(pad_pkg::SEVERE_THRESHOLD_RST, pad_pkg::MIN_BASELINE_LEVEL_RST);

    // first sample alone, then a mean at the level boundary that stays out
    send_sample(150, 1'b0);
    send_sample(0, 1'b1);
    send_sample(200, 1'b0);
    // baseline fill; the completing sample makes no comparison
    for (int i = 0; i < pad_pkg::BASELINE_SAMPLES; i++) send_sample(1000, i[0]);
    send_sample(65535, 1'b0);  // anomaly in manual mode
    send_sample(65535, 1'b1);  // anomaly while inspecting
    send_sample(0, 1'b1);
    send_sample(1000, 1'b1);
    send_sample(1000, 1'b0);   // back in range: restore
    send_sample(0, 1'b1);      // anomaly in automatic mode
    send_sample(1000, 1'b1);
    send_sample(1000, 1'b1);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct = 28;
          recv_stall_pct = 28;
        end
      endcase
      thr = (p == NUM_PHASES - 1) ? $urandom_range(0, 1000) : THR_SET[p];
      write_regs(thr, LVL_SET[p]);
      spread = (thr > 6000) ? 20000 : 3 * int'(thr) + 8;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 80) begin
          v = sb.baseline_center() + int'($urandom_range(0, 2 * spread)) - spread;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          send_sample(unsigned'(v), 1'($urandom_range(0, 1)));
        end else begin
          case ($urandom_range(0, 9))
            0: send_sample(0, 1'($urandom_range(0, 1)));
            1: send_sample(65535, 1'($urandom_range(0, 1)));
            default: send_sample($urandom_range(0, 65535), 1'($urandom_range(0, 1)));
          endcase
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    $display("Covered %0d samples, %0d results over %0d register settings and 4 flow modes",
             sb.n_samples, sb.n_results, NUM_PHASES + 1);
    $display("Inspections started: %0d, restores: %0d, mismatches: %0d",
             sb.n_started, sb.n_restored, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/pad_pkg.sv
rtl/pad_core.sv
rtl/profile_anomaly_detector.sv
test/profile_anomaly_detector_tb.sv
